// File: hw/rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types, field widths and codes of the first-fit region allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffra_pkg;

    localparam int CMD_W   = 1;
    localparam int OWN_W   = 3;
    localparam int BYTES_W = 32;
    localparam int ST_W    = 3;

    localparam int FREE_SLOTS_DEF = 32;
    localparam int OWNERS_DEF     = 8;
    localparam int USED_SLOTS_DEF = 32;

    localparam logic [BYTES_W-1:0] POOL_RESET = 32'd65536;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NOFIT     = 3'd2,
        ST_LISTFULL  = 3'd3,
        ST_TABLEFULL = 3'd4
    } t_status;

    typedef struct packed {
        logic [BYTES_W-1:0] rs;
        logic [BYTES_W-1:0] re;
    } t_region;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: hw/rtl/ffra_if.sv
// ----------------------------------------------------------------------------
// ffra_if
// Request and response channels of the first-fit region allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffra_req_if import ffra_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [OWN_W-1:0]   owner;
    logic [BYTES_W-1:0] request_bytes;

    modport source (output valid, command, owner, request_bytes, input ready);
    modport sink   (input valid, command, owner, request_bytes, output ready);
endinterface

interface ffra_rsp_if import ffra_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ST_W-1:0]    status;
    logic [BYTES_W-1:0] region_offset;
    logic [BYTES_W-1:0] released_bytes;

    modport source (output valid, status, region_offset, released_bytes, input ready);
    modport sink   (input valid, status, region_offset, released_bytes, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ffra_ram.sv
// ----------------------------------------------------------------------------
// ffra_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_ram #(
    parameter int W = 32,
    parameter int D = 32,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/ffra_cell.sv
// ----------------------------------------------------------------------------
// ffra_cell
// One free-table entry; loads from the shared bus or takes its neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_cell import ffra_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire t_region   i_nbr,
    input  wire t_region   i_bus,
    output t_region        o_ent
);

    t_region r_ent;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ent <= i_bus;
        end else if (i_ctl.shift) begin
            r_ent <= i_nbr;
        end
    end

    assign o_ent = r_ent;

endmodule

`default_nettype wire

// File: hw/rtl/first_fit_region_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator_core
// First-fit pool allocator with an ordered free table and per-owner release.
// ----------------------------------------------------------------------------
// Requests arrive as beats on i_req (command, owner, request_bytes); each one
// gives exactly one response beat on o_rsp (status, region_offset,
// released_bytes). One request is worked on at a time.
// For an allocate, the free table sits in a chain of cells that rotates one
// entry per cycle past the head cell, where the first fitting region is
// carved. A release streams the owner list of n pieces from the one read
// port of the used-list RAM, one piece per cycle.
// The response is held in an output register; while the receiver stalls,
// the block finishes the next request and then waits with it.
// Reset, and every write of i_cfg_wdata (pool size, 65536 after reset), set
// the free table to one region from zero, the free byte count to the pool
// size and empty all owner lists at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_region_allocator_core import ffra_pkg::*; #(
    parameter int FREE_SLOTS = FREE_SLOTS_DEF,
    parameter int OWNERS     = OWNERS_DEF,
    parameter int USED_SLOTS = USED_SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [BYTES_W-1:0] i_cfg_wdata,
    ffra_req_if.sink                i_req,
    ffra_rsp_if.source              o_rsp
);

    localparam int FCW = $clog2(FREE_SLOTS + 1);
    localparam int UCW = $clog2(USED_SLOTS + 1);
    localparam int OW  = (OWNERS > 1) ? $clog2(OWNERS) : 1;
    localparam int UAW = (OWNERS * USED_SLOTS > 1) ? $clog2(OWNERS * USED_SLOTS) : 1;

    typedef enum logic [2:0] {S_IDLE, S_CHK, S_SCAN, S_REL, S_RFIN, S_DONE} t_state;

    t_state             r_state;
    logic [CMD_W-1:0]   r_cmd;
    logic [OW-1:0]      r_own;
    logic [BYTES_W-1:0] r_size;
    logic [FCW-1:0]     r_fcnt;
    logic [FCW-1:0]     r_fsave;
    logic [FCW-1:0]     r_left;
    logic [BYTES_W-1:0] r_fbytes;
    logic [OWNERS-1:0]  r_cvld;
    logic [UCW-1:0]     r_ucnt;
    logic [UCW-1:0]     r_seen;
    logic               r_hit;
    logic               r_full;
    t_region            r_run;
    logic [BYTES_W-1:0] r_sum;
    t_status            r_st;
    logic [BYTES_W-1:0] r_off;
    logic [BYTES_W-1:0] r_rel;
    logic               r_ovalid;
    t_status            r_o_st;
    logic [BYTES_W-1:0] r_o_off;
    logic [BYTES_W-1:0] r_o_rel;

    logic [OW-1:0]      w_own;
    logic [UCW-1:0]     w_cnt_rd;
    logic [UCW-1:0]     w_cnt;
    logic [UAW-1:0]     w_base;
    logic [UCW-1:0]     w_nxt;
    t_region            w_ud;
    t_region            w_head;
    t_region            w_ins;
    t_region            w_bus;
    logic [BYTES_W-1:0] w_cs;
    logic               w_fit;
    logic               w_drop;
    logic               w_init;
    logic               w_step;
    logic               w_emit;
    logic               w_app_ok;
    logic               w_app;
    logic               w_accept;
    logic               w_cnt_we;
    logic [OW-1:0]      w_cnt_raddr;
    logic               w_used_we;
    logic [UAW-1:0]     w_used_waddr;
    logic [UAW-1:0]     w_used_raddr;
    t_region            w_used_wdata;
    t_region            w_ent [FREE_SLOTS];

    always_comb begin
        logic [6:0] v_own;
        v_own = {4'b0, i_req.owner};
        for (int j = 0; j < 8; j++) begin
            if (v_own >= 7'(OWNERS)) begin
                v_own = v_own - 7'(OWNERS);
            end
        end
        w_own = OW'(v_own);
    end

    assign w_accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign w_cnt   = r_cvld[r_own] ? w_cnt_rd : '0;
    assign w_base  = UAW'(r_own) * UAW'(USED_SLOTS);
    assign w_nxt   = r_seen + 1'b1;

    assign w_head  = w_ent[0];
    assign w_step  = (r_state == S_SCAN) && (r_left != '0);
    assign w_fit   = !r_hit && ((w_head.re - w_head.rs) >= r_size) && (w_head.re >= w_head.rs);
    assign w_cs    = w_head.rs + r_size;
    assign w_drop  = w_fit && (w_cs == w_head.re);
    assign w_ins   = w_fit ? t_region'{rs: w_cs, re: w_head.re} : w_head;

    assign w_emit   = ((r_state == S_REL) && (r_seen != '0) && (r_run.re != w_ud.rs))
                   || (r_state == S_RFIN);
    assign w_app_ok = (r_fcnt != FCW'(FREE_SLOTS));
    assign w_app    = w_emit && w_app_ok && !r_full;

    assign w_init = !i_rst_n || i_cfg_we;

    always_comb begin
        if (w_init) begin
            w_bus = '{rs: '0, re: (!i_rst_n ? POOL_RESET : i_cfg_wdata)};
        end else if (r_state == S_SCAN) begin
            w_bus = w_ins;
        end else begin
            w_bus = r_run;
        end
    end

    genvar k;
    for (k = 0; k < FREE_SLOTS; k++) begin : g_cell
        t_cell_ctl w_ctl;
        t_region   w_nbr;

        assign w_ctl = '{
            shift: w_step,
            load:  (w_init && (k == 0))
                || (!w_init && w_step && !w_drop && (r_fcnt == FCW'(k + 1)))
                || (!w_init && w_app && (r_fcnt == FCW'(k)))
        };

        if (k == FREE_SLOTS - 1) begin : g_last
            assign w_nbr = w_bus;
        end else begin : g_mid
            assign w_nbr = w_ent[k + 1];
        end

        ffra_cell u_cell (
            .i_clk (i_clk),
            .i_ctl (w_ctl),
            .i_nbr (w_nbr),
            .i_bus (w_bus),
            .o_ent (w_ent[k])
        );
    end

    assign w_cnt_raddr  = (r_state == S_IDLE) ? w_own : r_own;
    assign w_cnt_we     = (r_state == S_SCAN) && (r_left == '0) && r_hit;
    assign w_used_we    = w_cnt_we;
    assign w_used_waddr = w_base + UAW'(r_ucnt);
    assign w_used_wdata = '{rs: r_off, re: r_off + r_size};
    assign w_used_raddr = ((r_state == S_REL) && (w_nxt < r_ucnt)) ? w_base + UAW'(w_nxt)
                                                                   : w_base;

    ffra_ram #(.W(UCW), .D(OWNERS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (r_own),
        .i_wdata (r_ucnt + 1'b1),
        .i_raddr (w_cnt_raddr),
        .o_rdata (w_cnt_rd)
    );

    ffra_ram #(.W($bits(t_region)), .D(OWNERS * USED_SLOTS)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (w_used_we),
        .i_waddr (w_used_waddr),
        .i_wdata (w_used_wdata),
        .i_raddr (w_used_raddr),
        .o_rdata (w_ud)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_fcnt   <= FCW'(1);
            r_fbytes <= POOL_RESET;
            r_cvld   <= '0;
            r_hit    <= 1'b0;
            r_full   <= 1'b0;
        end else begin
            if (r_ovalid && o_rsp.ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_fcnt   <= FCW'(1);
                r_fbytes <= i_cfg_wdata;
                r_cvld   <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= i_req.command;
                        r_own   <= w_own;
                        r_size  <= i_req.request_bytes;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_ucnt <= w_cnt;
                    r_off  <= '0;
                    r_rel  <= '0;
                    if (r_cmd == CMD_ALLOC) begin
                        if (r_fbytes < r_size) begin
                            r_st    <= ST_SHORT;
                            r_state <= S_DONE;
                        end else if (w_cnt >= UCW'(USED_SLOTS)) begin
                            r_st    <= ST_LISTFULL;
                            r_state <= S_DONE;
                        end else begin
                            r_left  <= r_fcnt;
                            r_hit   <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end else if (w_cnt == '0) begin
                        r_st    <= ST_OK;
                        r_state <= S_DONE;
                    end else begin
                        r_seen  <= '0;
                        r_sum   <= '0;
                        r_full  <= 1'b0;
                        r_fsave <= r_fcnt;
                        r_state <= S_REL;
                    end
                end
                S_SCAN: begin
                    if (r_left != '0) begin
                        r_left <= r_left - 1'b1;
                        if (w_fit) begin
                            r_hit <= 1'b1;
                            r_off <= w_head.rs;
                        end
                        if (w_drop) begin
                            r_fcnt <= r_fcnt - 1'b1;
                        end
                    end else begin
                        if (r_hit) begin
                            r_st     <= ST_OK;
                            r_fbytes <= r_fbytes - r_size;
                            r_cvld[r_own] <= 1'b1;
                        end else begin
                            r_st  <= ST_NOFIT;
                            r_off <= '0;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_REL: begin
                    r_sum  <= r_sum + (w_ud.re - w_ud.rs);
                    r_seen <= w_nxt;
                    if (r_seen == '0) begin
                        r_run <= w_ud;
                    end else if (r_run.re == w_ud.rs) begin
                        r_run.re <= w_ud.re;
                    end else begin
                        r_run <= w_ud;
                        if (w_app) begin
                            r_fcnt <= r_fcnt + 1'b1;
                        end else begin
                            r_full <= 1'b1;
                        end
                    end
                    if (w_nxt == r_ucnt) begin
                        r_state <= S_RFIN;
                    end
                end
                S_RFIN: begin
                    if (w_app) begin
                        r_fcnt   <= r_fcnt + 1'b1;
                        r_st     <= ST_OK;
                        r_rel    <= r_sum;
                        r_fbytes <= r_fbytes + r_sum;
                        r_cvld[r_own] <= 1'b0;
                    end else begin
                        r_fcnt <= r_fsave;
                        r_st   <= ST_TABLEFULL;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid <= 1'b1;
                        r_o_st   <= r_st;
                        r_o_off  <= r_off;
                        r_o_rel  <= r_rel;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.status         = r_o_st;
    assign o_rsp.region_offset  = r_o_off;
    assign o_rsp.released_bytes = r_o_rel;

endmodule

`default_nettype wire
